### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(name, prop, msg)
`define ASSERT_CLK_ALWAYS(name, prop, msg)

`endif

`endif

### hw/rtl/cfts_pkg.sv
package cfts_pkg;

  // frame layout
  localparam int PAYLOAD_BYTES = 2048;
  localparam int TIME_OFFSET   = 16;
  localparam int POS_W         = 12;

  localparam logic [POS_W-1:0] POS_PAYLOAD_END = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_LAST        = POS_W'(PAYLOAD_BYTES + 3);
  localparam logic [POS_W-1:0] POS_TIME_FIRST  = POS_W'(TIME_OFFSET);
  localparam logic [POS_W-1:0] POS_TIME_LAST   = POS_W'(TIME_OFFSET + 5);

  // crc-32, msb first, no reflection
  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;

  // gps time conversion to half milliseconds
  localparam logic [46:0] HALF_MS_PER_WEEK   = 47'd1209600000;
  localparam logic [30:0] HALF_MS_PER_SECOND = 31'd2000;

  localparam logic [15:0] SEG_MAX = 16'hFFFF;

  // one byte of crc update, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/cfts_time_conv.sv
module cfts_time_conv
  import cfts_pkg::*;
(
  input  logic        clk,
  input  logic [47:0] time_raw,
  output logic [46:0] time_half_ms
);

  logic [46:0] week_prod;
  logic [30:0] sec_prod;
  logic [11:0] sub_q;

  // stage 1: constant products of week and second fields
  always_ff @(posedge clk) begin
    week_prod <= 47'(time_raw[47:32]) * HALF_MS_PER_WEEK;
    sec_prod  <= 31'(time_raw[31:12]) * HALF_MS_PER_SECOND;
    sub_q     <= time_raw[11:0];
  end

  // stage 2: final sum
  always_ff @(posedge clk) begin
    time_half_ms <= week_prod + 47'(sec_prod) + 47'(sub_q);
  end

endmodule

### hw/rtl/crc_checked_frame_time_segmenter_core.sv
// A result is registered as the last trailer byte of a frame is processed.
// Throughput: one byte per cycle unless a held result stalls the final byte; byte-wise
// crc update and field capture sit between the input and the state/result registers.
// The gps time conversion runs in a 2-stage constant-multiply pipeline behind the capture.
// Reset (rst, synchronous, active high) clears frame position, crc, capture and segment state.
`include "assert_macros.svh"

module crc_checked_frame_time_segmenter_core
  import cfts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        crc_ok,
  output logic        new_segment,
  output logic [15:0] segment_index,
  output logic [46:0] frame_time,
  output logic [31:0] computed_crc,
  output logic [31:0] received_crc
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;

  logic [POS_W-1:0] byte_position;
  logic [31:0]      crc_remainder;
  logic [31:0]      trailer_word;
  logic [47:0]      time_capture;
  logic [46:0]      previous_time;
  logic             seen_good_frame;
  logic [15:0]      segment_count;

  logic [46:0]      time_half_ms;

  logic             at_last;
  logic             in_payload;
  logic             in_time_field;
  logic             res_free;
  logic             proc;
  logic             last_go;
  logic [31:0]      crc_next;
  logic [31:0]      trailer_next;
  logic             crc_match;
  logic             earlier;
  logic             fresh;
  logic [15:0]      segment_count_next;

  // time conversion pipeline
  cfts_time_conv u_time_conv (
    .clk          (clk),
    .time_raw     (time_capture),
    .time_half_ms (time_half_ms)
  );

  // handshake: only the final byte of a frame waits on the result register
  assign at_last       = (byte_position == POS_LAST);
  assign in_payload    = (byte_position < POS_PAYLOAD_END);
  assign in_time_field = (byte_position >= POS_TIME_FIRST) && (byte_position <= POS_TIME_LAST);
  assign res_free      = !result_valid || !result_stall;
  assign proc          = in_valid_q && (!at_last || res_free);
  assign last_go       = proc && at_last;
  assign byte_stall    = in_valid_q && !proc;

  // per-byte datapath
  assign crc_next     = crc_byte(crc_remainder, in_byte_q);
  assign trailer_next = {trailer_word[23:0], in_byte_q};
  assign crc_match    = (crc_remainder == trailer_next);
  assign earlier      = (time_half_ms < previous_time);
  assign fresh        = crc_match && (!seen_good_frame || earlier);

  // segment numbering, saturating
  always_comb begin
    if (!seen_good_frame) begin
      segment_count_next = '0;
    end else if (earlier && (segment_count != SEG_MAX)) begin
      segment_count_next = segment_count + 16'd1;
    end else begin
      segment_count_next = segment_count;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!byte_stall) begin
      in_valid_q <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte_q <= data_byte;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_remainder   <= '0;
      trailer_word    <= '0;
      time_capture    <= '0;
      previous_time   <= '0;
      seen_good_frame <= 1'b0;
      segment_count   <= '0;
    end else if (proc) begin
      if (in_payload) begin
        crc_remainder <= crc_next;
        byte_position <= byte_position + POS_W'(1);
        if (in_time_field) begin
          time_capture <= {time_capture[39:0], in_byte_q};
        end
      end else begin
        trailer_word <= trailer_next;
        if (at_last) begin
          byte_position <= '0;
          crc_remainder <= '0;
          if (crc_match) begin
            previous_time   <= time_half_ms;
            seen_good_frame <= 1'b1;
            segment_count   <= segment_count_next;
          end
        end else begin
          byte_position <= byte_position + POS_W'(1);
        end
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (last_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (last_go) begin
      crc_ok        <= crc_match;
      new_segment   <= fresh;
      segment_index <= crc_match ? segment_count_next : 16'd0;
      frame_time    <= crc_match ? time_half_ms : 47'd0;
      computed_crc  <= crc_remainder;
      received_crc  <= trailer_next;
    end
  end

  // checks
  `ASSERT_CLK(a_result_from_last_byte, $rose(result_valid) |-> $past(last_go), "no final byte")
  `ASSERT_CLK(a_crc_clear_at_frame_start, (byte_position == '0) |-> (crc_remainder == '0), "crc")
  `ASSERT_CLK(a_new_segment_needs_good_crc, (result_valid && new_segment) |-> crc_ok, "bad crc")
  `ASSERT_CLK(a_position_in_frame, byte_position <= POS_LAST, "byte position beyond frame")

endmodule
